### rtl/assert_macros.svh
// Assertion helpers; clk_i and rst_ni must exist in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, prop)
`define ASSERT_IMPL(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### rtl/sukl_pkg.sv
`timescale 1ns / 1ps

package sukl_pkg;

  localparam int unsigned Capacity = 32;
  localparam int unsigned CntW     = $clog2(Capacity + 1);
  localparam int unsigned AddrW    = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned KeyW     = 32;
  localparam int unsigned CmdW     = 2;
  localparam int unsigned StatW    = 3;

  typedef enum logic [CmdW-1:0] {
    CMD_INSERT    = 2'd0,
    CMD_REMOVE    = 2'd1,
    CMD_LIST_ASC  = 2'd2,
    CMD_LIST_DESC = 2'd3
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_REMOVED   = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_ENTRY     = 3'd5,
    ST_EMPTY     = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    WALK_IDLE,
    WALK_SEARCH,
    WALK_UP,
    WALK_DN,
    WALK_LIST
  } walk_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_UP,
    S_DN,
    S_LIST,
    S_RESP
  } state_e;

  typedef struct packed {
    logic    ld;
    logic    start_up;
    logic    start_dn;
    walk_e   walk;
    logic    rsp_ld;
    status_e rsp_status;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic eq;
    logic full;
    logic empty;
    logic out_free;
  } dp_stat_t;

endpackage

### rtl/sukl_if.sv
`timescale 1ns / 1ps

interface sukl_req_if;
  import sukl_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CmdW-1:0]        command;
  logic signed [KeyW-1:0] key;

  modport source (output valid, command, key, input ready);
  modport sink (input valid, command, key, output ready);
endinterface

interface sukl_rsp_if;
  import sukl_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [StatW-1:0]       status;
  logic signed [KeyW-1:0] value;
  logic                   last;

  modport source (output valid, status, value, last, input ready);
  modport sink (input valid, status, value, last, output ready);
endinterface

### rtl/sukl_dp.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sukl_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  sukl_pkg::dp_cmd_t               ctl_i,
  output sukl_pkg::dp_stat_t              stat_o,
  input  logic [sukl_pkg::CmdW-1:0]       command_i,
  input  logic signed [sukl_pkg::KeyW-1:0] key_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output sukl_pkg::status_e               out_status_o,
  output logic signed [sukl_pkg::KeyW-1:0] out_value_o,
  output logic                            out_last_o
);
  import sukl_pkg::*;

  logic [KeyW-1:0]        mem [Capacity];
  logic [KeyW-1:0]        rdata_q;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [CntW-1:0]        idx_q, idx_d, idx_dec;
  logic [CntW-1:0]        pos_q, srch_pos;
  logic [AddrW-1:0]       cmp_q;
  logic                   rv_q, rv_d;
  cmd_e                   cmd_q;
  logic signed [KeyW-1:0] key_q;

  logic                   rd_en, we, done, hit, adv, entry_ld, entry_last;
  logic [AddrW-1:0]       raddr, waddr;
  logic [KeyW-1:0]        wdata;

  logic                   out_valid_q;
  status_e                out_status_q;
  logic signed [KeyW-1:0] out_value_q;
  logic                   out_last_q;

  assign adv      = !out_valid_q || out_ready_i;
  assign hit      = rv_q && ($signed(rdata_q) >= key_q);
  assign srch_pos = hit ? CntW'(cmp_q) : cnt_q;
  assign idx_dec  = idx_q - CntW'(1);
  assign entry_last = (cmd_q == CMD_LIST_ASC) ? (CntW'(cmp_q) == cnt_q - CntW'(1))
                                              : (cmp_q == '0);

  always_comb begin
    rd_en    = 1'b0;
    raddr    = idx_q[AddrW-1:0];
    idx_d    = idx_q;
    we       = 1'b0;
    waddr    = cmp_q;
    wdata    = rdata_q;
    cnt_d    = cnt_q;
    done     = 1'b0;
    rv_d     = 1'b0;
    entry_ld = 1'b0;
    case (ctl_i.walk)
      WALK_SEARCH: begin
        rd_en = idx_q < cnt_q;
        if (rd_en) idx_d = idx_q + CntW'(1);
        rv_d  = rd_en;
        done  = hit || (!rv_q && (idx_q >= cnt_q));
      end
      WALK_UP: begin
        rd_en = idx_q > pos_q;
        raddr = idx_dec[AddrW-1:0];
        if (rd_en) idx_d = idx_dec;
        rv_d  = rd_en;
        if (rv_q) begin
          we    = 1'b1;
          waddr = cmp_q + AddrW'(1);
        end
        done = !rv_q && (idx_q <= pos_q);
        if (done) begin
          we    = 1'b1;
          waddr = pos_q[AddrW-1:0];
          wdata = $unsigned(key_q);
          cnt_d = cnt_q + CntW'(1);
        end
      end
      WALK_DN: begin
        rd_en = idx_q < cnt_q;
        if (rd_en) idx_d = idx_q + CntW'(1);
        rv_d  = rd_en;
        if (rv_q) begin
          we    = 1'b1;
          waddr = cmp_q - AddrW'(1);
        end
        done = !rv_q && (idx_q >= cnt_q);
        if (done) cnt_d = cnt_q - CntW'(1);
      end
      WALK_LIST: begin
        if (cmd_q == CMD_LIST_ASC) begin
          rd_en = adv && (idx_q < cnt_q);
          if (rd_en) idx_d = idx_q + CntW'(1);
        end else begin
          rd_en = adv && (idx_q != '0);
          raddr = idx_dec[AddrW-1:0];
          if (rd_en) idx_d = idx_dec;
        end
        rv_d     = adv ? rd_en : rv_q;
        entry_ld = adv && rv_q;
        done     = entry_ld && entry_last;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
    if (ctl_i.ld) begin
      idx_d = (cmd_e'(command_i) == CMD_LIST_DESC) ? cnt_q : '0;
      rv_d  = 1'b0;
    end
    if (ctl_i.start_up) begin
      idx_d = cnt_q;
      rv_d  = 1'b0;
    end
    if (ctl_i.start_dn) begin
      idx_d = srch_pos + CntW'(1);
      rv_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (rd_en) begin
      rdata_q <= mem[raddr];
      cmp_q   <= raddr;
    end
    if (ctl_i.ld) begin
      cmd_q <= cmd_e'(command_i);
      key_q <= key_i;
    end
    if (ctl_i.rsp_ld) begin
      out_status_q <= ctl_i.rsp_status;
      out_value_q  <= (ctl_i.rsp_status == ST_EMPTY) ? '0 : key_q;
      out_last_q   <= 1'b1;
    end else if (entry_ld) begin
      out_status_q <= ST_ENTRY;
      out_value_q  <= $signed(rdata_q);
      out_last_q   <= entry_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      idx_q       <= '0;
      pos_q       <= '0;
      rv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
      rv_q  <= rv_d;
      if (ctl_i.walk == WALK_SEARCH) pos_q <= srch_pos;
      if (ctl_i.rsp_ld || entry_ld) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.done     = done;
  assign stat_o.eq       = hit && (rdata_q == $unsigned(key_q));
  assign stat_o.full     = cnt_q == CntW'(Capacity);
  assign stat_o.empty    = cnt_q == '0;
  assign stat_o.out_free = adv;

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_value_o  = out_value_q;
  assign out_last_o   = out_last_q;

  `ASSERT_ALWAYS(a_cnt_range, cnt_q <= CntW'(Capacity))
  `ASSERT_IMPL(a_wr_shift_only, we, (ctl_i.walk == WALK_UP) || (ctl_i.walk == WALK_DN))
  `ASSERT_NEXT(a_ins_grows, (ctl_i.walk == WALK_UP) && done, cnt_q == $past(cnt_q) + CntW'(1))
  `ASSERT_NEXT(a_rm_shrinks, (ctl_i.walk == WALK_DN) && done, cnt_q == $past(cnt_q) - CntW'(1))

endmodule

### rtl/sukl_ctrl.sv
`timescale 1ns / 1ps

module sukl_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [sukl_pkg::CmdW-1:0] command_i,
  input  sukl_pkg::dp_stat_t        stat_i,
  output sukl_pkg::dp_cmd_t         ctl_o
);
  import sukl_pkg::*;

  state_e  state_q, state_d;
  cmd_e    op_q, op_d;
  status_e status_q, status_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      op_q     <= CMD_INSERT;
      status_q <= ST_INSERTED;
    end else begin
      state_q  <= state_d;
      op_q     <= op_d;
      status_q <= status_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    op_d             = op_q;
    status_d         = status_q;
    in_ready_o       = 1'b0;
    ctl_o            = '0;
    ctl_o.walk       = WALK_IDLE;
    ctl_o.rsp_status = status_q;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.ld = 1'b1;
          op_d     = cmd_e'(command_i);
          case (cmd_e'(command_i))
            CMD_INSERT, CMD_REMOVE: state_d = S_SEARCH;
            CMD_LIST_ASC, CMD_LIST_DESC: begin
              if (stat_i.empty) begin
                status_d = ST_EMPTY;
                state_d  = S_RESP;
              end else begin
                state_d = S_LIST;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_SEARCH: begin
        ctl_o.walk = WALK_SEARCH;
        if (stat_i.done) begin
          if (op_q == CMD_INSERT) begin
            if (stat_i.eq) begin
              status_d = ST_DUPLICATE;
              state_d  = S_RESP;
            end else if (stat_i.full) begin
              status_d = ST_FULL;
              state_d  = S_RESP;
            end else begin
              ctl_o.start_up = 1'b1;
              state_d        = S_UP;
            end
          end else if (stat_i.eq) begin
            ctl_o.start_dn = 1'b1;
            state_d        = S_DN;
          end else begin
            status_d = ST_NOT_FOUND;
            state_d  = S_RESP;
          end
        end
      end
      S_UP: begin
        ctl_o.walk = WALK_UP;
        if (stat_i.done) begin
          status_d = ST_INSERTED;
          state_d  = S_RESP;
        end
      end
      S_DN: begin
        ctl_o.walk = WALK_DN;
        if (stat_i.done) begin
          status_d = ST_REMOVED;
          state_d  = S_RESP;
        end
      end
      S_LIST: begin
        ctl_o.walk = WALK_LIST;
        if (stat_i.done) state_d = S_IDLE;
      end
      S_RESP: begin
        ctl_o.rsp_ld = stat_i.out_free;
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

### rtl/sorted_unique_key_list_core.sv
`timescale 1ns / 1ps
// channel  dir  handshake     payload
// req_i    in   valid/ready   command[1:0], key[31:0] signed
// rsp_o    out  valid/ready   status[2:0], value[31:0] signed, last
//
// One request at a time; the key memory has one read and one write port and is
// walked one entry per cycle while the output is not stalled. An insert or remove
// searches, then shifts later keys when the set changes; a list reads each entry.
// Reset clears counts and valid flags only; memory is never read before written.
// A pending response sits in an output register; a stalled list pauses its walk.

module sorted_unique_key_list_core (
  input logic       clk_i,
  input logic       rst_ni,
  sukl_req_if.sink   req_i,
  sukl_rsp_if.source rsp_o
);
  import sukl_pkg::*;

  dp_cmd_t  ctl;
  dp_stat_t stat;
  status_e  out_status;

  sukl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .command_i  (req_i.command),
    .stat_i     (stat),
    .ctl_o      (ctl)
  );

  sukl_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .stat_o       (stat),
    .command_i    (req_i.command),
    .key_i        (req_i.key),
    .out_valid_o  (rsp_o.valid),
    .out_ready_i  (rsp_o.ready),
    .out_status_o (out_status),
    .out_value_o  (rsp_o.value),
    .out_last_o   (rsp_o.last)
  );

  assign rsp_o.status = out_status;

endmodule

### verif/tb_sorted_unique_key_list_core.sv
`timescale 1ns / 1ps

import sukl_pkg::*;

typedef struct packed {
  status_e                status;
  logic signed [KeyW-1:0] value;
  logic                   last;
} key_rsp_t;

class key_set_scoreboard;
  logic signed [KeyW-1:0] stored_keys [Capacity];
  int                     key_count = 0;
  key_rsp_t               expected_rsp [$];
  int                     mismatches = 0;

  function void expect_rsp(status_e status, logic signed [KeyW-1:0] value, logic last);
    key_rsp_t r;
    r.status = status;
    r.value  = value;
    r.last   = last;
    expected_rsp.push_back(r);
  endfunction

  function void note_request(cmd_e cmd, logic signed [KeyW-1:0] key);
    int  pos;
    int  n;
    bit  hit;
    n   = key_count;
    pos = 0;
    while (pos < n && stored_keys[pos] < key) pos++;
    hit = (pos < n) && (stored_keys[pos] == key);
    case (cmd)
      CMD_INSERT: begin
        if (hit) begin
          expect_rsp(ST_DUPLICATE, key, 1'b1);
        end else if (n >= Capacity) begin
          expect_rsp(ST_FULL, key, 1'b1);
        end else begin
          for (int i = n; i > pos; i--) stored_keys[i] = stored_keys[i-1];
          stored_keys[pos] = key;
          key_count = n + 1;
          expect_rsp(ST_INSERTED, key, 1'b1);
        end
      end
      CMD_REMOVE: begin
        if (hit) begin
          for (int i = pos; i + 1 < n; i++) stored_keys[i] = stored_keys[i+1];
          key_count = n - 1;
          expect_rsp(ST_REMOVED, key, 1'b1);
        end else begin
          expect_rsp(ST_NOT_FOUND, key, 1'b1);
        end
      end
      default: begin
        if (n == 0) begin
          expect_rsp(ST_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < n; i++)
            expect_rsp(ST_ENTRY, stored_keys[(cmd == CMD_LIST_ASC) ? i : n - 1 - i],
                       i == n - 1);
        end
      end
    endcase
  endfunction

  function void check_response(logic [StatW-1:0] status, logic signed [KeyW-1:0] value,
                               logic last);
    key_rsp_t e;
    if (expected_rsp.size() == 0) begin
      $error("unexpected response: status %0d value %0d last %0d", status, value, last);
      mismatches++;
      return;
    end
    e = expected_rsp.pop_front();
    if (status !== e.status) begin
      $error("status: expected %0d, got %0d", e.status, status);
      mismatches++;
    end
    if (value !== e.value) begin
      $error("value: expected %0d, got %0d", e.value, value);
      mismatches++;
    end
    if (last !== e.last) begin
      $error("last: expected %0d, got %0d", e.last, last);
      mismatches++;
    end
  endfunction
endclass

module tb_sorted_unique_key_list_core;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic no_idle = 1'b0;

  key_set_scoreboard      sb;
  logic signed [KeyW-1:0] used_keys [$];

  sukl_req_if req_if ();
  sukl_rsp_if rsp_if ();

  sorted_unique_key_list_core uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always #5 clk = ~clk;

  initial begin
    #8_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && rsp_if.valid && rsp_if.ready)
      sb.check_response(rsp_if.status, rsp_if.value, rsp_if.last);
    rsp_if.ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 20);
  end

  task automatic send(cmd_e cmd, logic signed [KeyW-1:0] key);
    while (!no_idle && $urandom_range(0, 99) < 20) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid   <= 1'b1;
    req_if.command <= cmd;
    req_if.key     <= key;
    do @(posedge clk); while (!req_if.ready);
    sb.note_request(cmd, key);
    if (cmd == CMD_INSERT) begin
      used_keys.push_back(key);
      if (used_keys.size() > 64) void'(used_keys.pop_front());
    end
  endtask

  function automatic logic signed [KeyW-1:0] fresh_key();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      1: return $signed($urandom_range(0, 16)) - 8;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [KeyW-1:0] old_key();
    if (used_keys.size() == 0) return fresh_key();
    return used_keys[$urandom_range(0, used_keys.size() - 1)];
  endfunction

  function automatic logic signed [KeyW-1:0] stored_key();
    if (sb.key_count == 0) return fresh_key();
    return sb.stored_keys[$urandom_range(0, sb.key_count - 1)];
  endfunction

  task automatic send_list();
    send($urandom_range(0, 1) ? CMD_LIST_ASC : CMD_LIST_DESC, $urandom);
  endtask

  initial begin
    int r;
    sb = new;
    req_if.valid   <= 1'b0;
    req_if.command <= CMD_INSERT;
    req_if.key     <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(CMD_LIST_ASC, 32'sh0);
    send(CMD_LIST_DESC, -32'sd1);
    send(CMD_REMOVE, 32'sd5);
    send(CMD_INSERT, 32'sh7fff_ffff);
    send(CMD_INSERT, 32'sh8000_0000);
    send(CMD_INSERT, 32'sd0);
    send(CMD_INSERT, -32'sd1);
    send(CMD_INSERT, 32'sd1);
    send(CMD_INSERT, 32'sh7fff_ffff);
    send(CMD_INSERT, 32'sh8000_0000);
    send(CMD_LIST_ASC, 32'sh5555_5555);
    send(CMD_LIST_DESC, 32'shaaaa_aaaa);
    send(CMD_REMOVE, 32'sd0);
    send(CMD_REMOVE, 32'sd0);
    send(CMD_REMOVE, 32'sh8000_0000);
    send(CMD_REMOVE, 32'sh7fff_ffff);
    send(CMD_REMOVE, 32'sd2);
    send(CMD_LIST_ASC, 32'sh0);
    send(CMD_REMOVE, -32'sd1);
    send(CMD_REMOVE, 32'sd1);
    send(CMD_LIST_DESC, 32'sh0);

    // let the block drain completely before the random part
    req_if.valid <= 1'b0;
    while (sb.expected_rsp.size() != 0) @(posedge clk);

    for (int round = 0; round < 4; round++) begin
      no_idle = (round == 2);
      for (int i = 0; i < 45 && sb.key_count < Capacity; i++) begin
        r = $urandom_range(0, 99);
        if (r < 8) send_list();
        else if (r < 20) send(CMD_INSERT, old_key());
        else send(CMD_INSERT, fresh_key());
      end
      send(CMD_INSERT, fresh_key());
      send(CMD_INSERT, stored_key());
      send_list();
      send(CMD_INSERT, fresh_key());
      send_list();
      for (int i = 0; i < 50 && sb.key_count > ((round % 2) ? 0 : 10); i++) begin
        r = $urandom_range(0, 99);
        if (r < 8) send_list();
        else if (r < 18) send(CMD_REMOVE, old_key());
        else if (r < 25) send(CMD_REMOVE, fresh_key());
        else send(CMD_REMOVE, stored_key());
      end
      send_list();
    end
    no_idle = 1'b0;

    repeat (50) begin
      r = $urandom_range(0, 99);
      if (r < 10) send_list();
      else if (r < 40) send(CMD_INSERT, fresh_key());
      else if (r < 55) send(CMD_INSERT, old_key());
      else if (r < 80) send(CMD_REMOVE, stored_key());
      else send(CMD_REMOVE, old_key());
    end
    send(CMD_LIST_ASC, $urandom);

    req_if.valid <= 1'b0;
    while (sb.expected_rsp.size() != 0) @(posedge clk);
    repeat (2 * Capacity + 10) @(posedge clk);

    if (sb.mismatches == 0 && sb.expected_rsp.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
